@@ rtl/kmer_repeat_masker_macros.svh @@
// Assertion macros for the k-mer repeat masker RTL.
// Included by rtl/kmer_repeat_masker.sv; has no dependencies of its own.
`ifndef KMER_REPEAT_MASKER_MACROS_SVH
`define KMER_REPEAT_MASKER_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define KRM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("kmer_repeat_masker: assertion failed");
// Antecedent implies consequent in the following cycle.
`define KRM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("kmer_repeat_masker: assertion failed");
`else
`define KRM_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define KRM_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/kmr_pkg.sv @@
// Shared types, constants and the base decoder of the k-mer repeat masker.
// No dependencies; imported by rtl/kmer_repeat_masker.sv.
package kmr_pkg;

    // default geometry
    localparam int WORD_LEN_DEF  = 8;
    localparam int MERGE_GAP_DEF = 4;

    // fixed field widths
    localparam int BYTE_W      = 8;
    localparam int TABLE_AW    = 16;
    localparam int COUNT_W     = 16;
    localparam int TABLE_DEPTH = 1 << TABLE_AW;
    localparam int IN_DATA_W   = BYTE_W + TABLE_AW + COUNT_W;
    localparam int CFG_DATA_W  = 16;

    typedef logic [BYTE_W-1:0]   t_byte;
    typedef logic [TABLE_AW-1:0] t_tidx;
    typedef logic [COUNT_W-1:0]  t_count;

    // request kinds on the input stream
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_SEQ  = 1'b1;

    // configuration register indexes
    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_MASK_CHAR = 1'b1;

    localparam t_count THRESHOLD_RST = 16'hFFFF;
    localparam t_byte  MASK_CHAR_RST = 8'h23;

    // characters
    localparam t_byte CHAR_PAD = 8'h2A;
    localparam t_byte CHAR_A   = 8'h41;
    localparam t_byte CHAR_C   = 8'h43;
    localparam t_byte CHAR_G   = 8'h47;
    localparam t_byte CHAR_T   = 8'h54;

    // base codes; bit 2 marks a non-base character
    localparam logic [2:0] BASE_A    = 3'd0;
    localparam logic [2:0] BASE_C    = 3'd1;
    localparam logic [2:0] BASE_G    = 3'd2;
    localparam logic [2:0] BASE_T    = 3'd3;
    localparam logic [2:0] BASE_NONE = 3'd4;

    // one result waiting on the output stream
    typedef struct packed {
        t_byte data;
        logic  masked;
        logic  last;
    } t_out;

    function automatic logic [2:0] base_code(input t_byte b);
        logic [2:0] code;
        case (b)
            CHAR_A:  code = BASE_A;
            CHAR_C:  code = BASE_C;
            CHAR_G:  code = BASE_G;
            CHAR_T:  code = BASE_T;
            default: code = BASE_NONE;
        endcase
        return code;
    endfunction

endpackage

@@ rtl/kmer_repeat_masker.sv @@
// K-mer frequency repeat masker: lookup pipeline, pending buffer and output queue.
// Depends on rtl/kmr_pkg.sv and rtl/kmer_repeat_masker_macros.svh.
//
// The block takes one request per cycle on the s_axis side when not stalled:
// either a count table load (tuser = 0) or a sequence byte (tuser = 1, tlast
// on the final byte). Each byte updates a rolling k-mer of WORD_LEN two-bit
// base codes and, once WORD_LEN bytes have gone by, looks its k-mer up in a
// 65536-entry count table held in one synchronous memory; a count at or
// above the threshold marks the last WORD_LEN bytes for masking. Bytes wait
// in a pending buffer of WORD_LEN + MERGE_GAP entries so that short unmasked
// gaps after a mask can be masked too, and leave through a two-entry output
// queue. Latency: a byte leaves once the buffer is full, i.e. WORD_LEN +
// MERGE_GAP bytes later, after the table read and the queue. Throughput is
// one request per cycle while the output queue has room and no flush is
// under way; the byte marked last stalls the input while the buffer drains.
// After reset the table is cleared one entry a cycle, so no request is taken
// until the clearing pass ends; configuration writes are taken at any time.
`include "kmer_repeat_masker_macros.svh"

module kmer_repeat_masker #(
    parameter int WORD_LEN  = kmr_pkg::WORD_LEN_DEF,
    parameter int MERGE_GAP = kmr_pkg::MERGE_GAP_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata: [7:0] base_byte, [23:8] table_index, [39:24] table_count
    input  logic [kmr_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  logic                        s_axis_tlast,   // last
    input  logic                        s_axis_tuser,   // command
    // result stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // tdata: [7:0] out_byte
    output logic [kmr_pkg::BYTE_W-1:0]  m_axis_tdata,
    output logic                        m_axis_tlast,   // out_last
    output logic                        m_axis_tuser,   // was_masked
    // configuration writes
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [kmr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import kmr_pkg::*;

    localparam int DEPTH  = WORD_LEN + MERGE_GAP;
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int KMER_W = 2 * WORD_LEN;
    localparam int POS_W  = $clog2(WORD_LEN + 1);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    t_count r_threshold;
    t_byte  r_mask_char;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_mask_char <= MASK_CHAR_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_THRESHOLD: r_threshold <= i_cfg_data;
                CFG_MASK_CHAR: r_mask_char <= i_cfg_data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input decode and k-mer front end
    // ---------------------------------------------------------------
    t_byte  in_byte;
    t_tidx  in_index;
    t_count in_count;
    logic   in_accept;
    logic   in_seq;
    logic   in_load;
    logic   in_pad;
    logic [2:0] in_code;
    logic [KMER_W-1:0] kmer_calc;

    logic              r_clearing;
    t_tidx             r_clr_addr;
    logic [KMER_W-1:0] r_kmer;
    logic [POS_W-1:0]  r_pos;

    // stage 1: byte waiting for its table read
    logic  r_s1_valid;
    t_byte r_s1_byte;
    logic  r_s1_last;
    logic  r_s1_lookup;
    logic  s1_consume;

    assign in_byte  = s_axis_tdata[BYTE_W-1:0];
    assign in_index = s_axis_tdata[BYTE_W +: TABLE_AW];
    assign in_count = s_axis_tdata[BYTE_W+TABLE_AW +: COUNT_W];

    assign s_axis_tready = !r_clearing && (!r_s1_valid || s1_consume);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_seq        = in_accept && (s_axis_tuser == CMD_SEQ);
    assign in_load       = in_accept && (s_axis_tuser == CMD_LOAD);
    assign in_pad        = (in_byte == CHAR_PAD);
    assign in_code       = base_code(in_byte);

    // non-base characters poison the whole window
    assign kmer_calc = in_code[2] ? {KMER_W{1'b1}}
                                  : {r_kmer[KMER_W-3:0], in_code[1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer <= '0;
            r_pos  <= '0;
        end else if (in_seq) begin
            if (s_axis_tlast) begin
                // sequence ends: restart the window for the next one
                r_kmer <= '0;
                r_pos  <= '0;
            end else begin
                if (!in_pad) begin
                    r_kmer <= kmer_calc;
                end
                if (r_pos != POS_W'(WORD_LEN)) begin
                    r_pos <= r_pos + 1'b1;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Count table: one synchronous memory, cleared by a sweep after reset
    // ---------------------------------------------------------------
    t_count r_table [TABLE_DEPTH];
    t_count r_rdata;
    logic   tbl_we;
    t_tidx  tbl_waddr;
    t_count tbl_wdata;

    assign tbl_we    = r_clearing || in_load;
    assign tbl_waddr = r_clearing ? r_clr_addr : in_index;
    assign tbl_wdata = r_clearing ? '0 : in_count;

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_table[tbl_waddr] <= tbl_wdata;
        end
        // read only on a new byte, so a stalled byte keeps its count
        if (in_seq) begin
            r_rdata <= r_table[t_tidx'(kmer_calc)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == {TABLE_AW{1'b1}}) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_seq) begin
            r_s1_valid <= 1'b1;
        end else if (s1_consume) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_seq) begin
            r_s1_byte   <= in_byte;
            r_s1_last   <= s_axis_tlast;
            // a pad never looks up; the position saturates at WORD_LEN
            r_s1_lookup <= !in_pad && (r_pos == POS_W'(WORD_LEN));
        end
    end

    // ---------------------------------------------------------------
    // Pending buffer: entry 0 is the oldest byte
    // ---------------------------------------------------------------
    t_byte             r_pbyte [DEPTH];
    logic [DEPTH-1:0]  r_pmask;
    logic [FILL_W-1:0] r_fill;
    logic              r_after;
    logic              r_flush;

    t_byte             n_pbyte [DEPTH];
    logic [DEPTH-1:0]  n_pmask;
    logic [FILL_W-1:0] n_fill;
    logic              n_after;
    logic              n_flush;

    logic [1:0] r_ocnt;
    logic       ofifo_space;
    logic       buf_full;
    logic       drain;
    logic       do_pop;
    logic       pop_mask;
    logic       pop_last;
    logic       s1_hit;
    logic [FILL_W-1:0] sh_fill;
    t_out       push_item;

    assign ofifo_space = (r_ocnt != 2'd2);
    assign buf_full    = (r_fill == FILL_W'(DEPTH));
    assign s1_hit      = r_s1_lookup && (r_rdata >= r_threshold);
    assign s1_consume  = r_s1_valid && !r_flush && (!buf_full || ofifo_space);
    assign drain       = r_flush && ofifo_space;
    assign do_pop      = drain || (s1_consume && buf_full);
    assign pop_last    = drain && (r_fill == FILL_W'(1));

    // Merge decision for the oldest byte: after a masked byte, a gap of at
    // most MERGE_GAP unmasked bytes closed by a mask or the buffer end is masked.
    always_comb begin
        logic gap_closed;
        gap_closed = 1'b0;
        for (int j = 1; j <= MERGE_GAP; j++) begin
            if ((FILL_W'(j) >= r_fill) || r_pmask[j]) begin
                gap_closed = 1'b1;
            end
        end
        pop_mask = r_pmask[0] || (r_after && gap_closed);
    end

    assign push_item.data   = pop_mask ? r_mask_char : r_pbyte[0];
    assign push_item.masked = pop_mask;
    assign push_item.last   = pop_last;

    always_comb begin
        logic [FILL_W-1:0] new_fill;
        // shift out the oldest byte when it leaves
        for (int i = 0; i < DEPTH; i++) begin
            n_pbyte[i] = r_pbyte[i];
            n_pmask[i] = r_pmask[i];
        end
        if (do_pop) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                n_pbyte[i] = r_pbyte[i+1];
                n_pmask[i] = r_pmask[i+1];
            end
        end
        sh_fill  = r_fill - FILL_W'(do_pop);
        new_fill = sh_fill;
        n_after  = r_after;
        n_flush  = r_flush;
        if (do_pop) begin
            n_after = pop_mask;
        end
        if (s1_consume) begin
            // append the new byte, then mark the last WORD_LEN bytes on a hit
            n_pbyte[sh_fill[IDX_W-1:0]] = r_s1_byte;
            n_pmask[sh_fill[IDX_W-1:0]] = 1'b0;
            new_fill = sh_fill + 1'b1;
            if (s1_hit) begin
                for (int i = 0; i < DEPTH; i++) begin
                    if ((FILL_W'(i) < new_fill) &&
                        ((FILL_W+1)'(i + WORD_LEN) >= {1'b0, new_fill})) begin
                        n_pmask[i] = 1'b1;
                    end
                end
            end
            if (r_s1_last) begin
                n_flush = 1'b1;
            end
        end
        if (pop_last) begin
            // flush done: back to an empty sequence state
            n_flush = 1'b0;
            n_after = 1'b0;
        end
        n_fill = new_fill;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            r_pbyte[i] <= n_pbyte[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pmask <= '0;
            r_fill  <= '0;
            r_after <= 1'b0;
            r_flush <= 1'b0;
        end else begin
            r_pmask <= n_pmask;
            r_fill  <= n_fill;
            r_after <= n_after;
            r_flush <= n_flush;
        end
    end

    // ---------------------------------------------------------------
    // Output queue: two entries, so the buffer never waits on m_axis_tready
    // within the same cycle
    // ---------------------------------------------------------------
    t_out r_ofifo [2];
    logic r_ord;
    logic r_owr;
    logic out_pop;

    assign m_axis_tvalid = (r_ocnt != 2'd0);
    assign out_pop       = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = r_ofifo[r_ord].data;
    assign m_axis_tuser  = r_ofifo[r_ord].masked;
    assign m_axis_tlast  = r_ofifo[r_ord].last;

    always_ff @(posedge i_clk) begin
        if (do_pop) begin
            r_ofifo[r_owr] <= push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ord  <= 1'b0;
            r_owr  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (do_pop) begin
                r_owr <= !r_owr;
            end
            if (out_pop) begin
                r_ord <= !r_ord;
            end
            r_ocnt <= r_ocnt + 2'(do_pop) - 2'(out_pop);
        end
    end

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `KRM_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FILL_W'(DEPTH))
    `KRM_ASSERT_IMP(a_flush_nonempty, i_clk, i_rst_n, r_flush, r_fill != '0)
    `KRM_ASSERT_IMP(a_flush_end_clean, i_clk, i_rst_n, $fell(r_flush),
                    (r_fill == '0) && !r_after)
    `KRM_ASSERT_IMP(a_clear_idle, i_clk, i_rst_n, r_clearing,
                    !r_s1_valid && (r_fill == '0) && (r_ocnt == 2'd0))

endmodule

@@ bench/tb_kmer_repeat_masker.sv @@
`timescale 1ns / 1ps
// Self-checking bench for kmer_repeat_masker: count table loads and sequence bytes go in,
// the masked byte stream is predicted in a scoreboard class and checked byte by byte.
// Depends on rtl/kmr_pkg.sv and the block itself.

package kmr_bench_pkg;
    import kmr_pkg::*;

    localparam int HOLD_DEPTH = WORD_LEN_DEF + MERGE_GAP_DEF;
    localparam int KMER_W     = 2 * WORD_LEN_DEF;

    class repeat_mask_scoreboard;
        t_count                threshold;
        t_byte                 mask_byte;
        t_count                counts [TABLE_DEPTH];
        logic [KMER_W-1:0]     kmer;
        int unsigned           seen;
        t_byte                 held_bytes[$];
        bit                    held_masks[$];
        bit                    after_mask;
        t_out                  due_bytes[$];
        int                    errors;
        int                    n_loads, n_bytes, n_seqs, n_out, n_masked;

        function new();
            threshold = THRESHOLD_RST;
            mask_byte = MASK_CHAR_RST;
            foreach (counts[i]) counts[i] = '0;
            errors   = 0;
            n_loads  = 0;
            n_bytes  = 0;
            n_seqs   = 0;
            n_out    = 0;
            n_masked = 0;
            restart();
        endfunction

        // Sequence state returns to reset after every flush; table and registers stay.
        function void restart();
            kmer       = '0;
            seen       = 0;
            after_mask = 1'b0;
            held_bytes.delete();
            held_masks.delete();
        endfunction

        function void set_reg(logic idx, t_count val);
            if (idx == CFG_THRESHOLD) begin
                threshold = val;
            end else begin
                mask_byte = val[BYTE_W-1:0];
            end
        endfunction

        // Send out the oldest held byte, merging a short gap that follows a mask.
        function void release_oldest(bit is_last);
            t_out r;
            bit   m;
            int   j;
            m = held_masks[0];
            if (!m && after_mask) begin
                for (j = 1; j <= MERGE_GAP_DEF; j++) begin
                    if (j >= held_masks.size() || held_masks[j]) begin
                        m = 1'b1;
                        break;
                    end
                end
            end
            r.data   = m ? mask_byte : held_bytes[0];
            r.masked = m;
            r.last   = is_last;
            due_bytes.push_back(r);
            after_mask = m;
            void'(held_bytes.pop_front());
            void'(held_masks.pop_front());
        endfunction

        function void note_request(logic cmd, t_byte b, logic is_last, t_tidx idx, t_count cnt);
            logic [2:0] code;
            int         span;
            int         i;
            if (cmd == CMD_LOAD) begin
                counts[idx] = cnt;
                n_loads++;
                return;
            end
            n_bytes++;
            if (held_bytes.size() >= HOLD_DEPTH) release_oldest(1'b0);
            held_bytes.push_back(b);
            held_masks.push_back(1'b0);
            if (b != CHAR_PAD) begin
                case (b)
                    CHAR_A:  code = BASE_A;
                    CHAR_C:  code = BASE_C;
                    CHAR_G:  code = BASE_G;
                    CHAR_T:  code = BASE_T;
                    default: code = BASE_NONE;
                endcase
                if (code == BASE_NONE) begin
                    kmer = '1;
                end else begin
                    kmer = {kmer[KMER_W-3:0], code[1:0]};
                end
                if (seen >= WORD_LEN_DEF && counts[kmer[TABLE_AW-1:0]] >= threshold) begin
                    span = held_masks.size() < WORD_LEN_DEF ? held_masks.size() : WORD_LEN_DEF;
                    for (i = held_masks.size() - span; i < held_masks.size(); i++)
                        held_masks[i] = 1'b1;
                end
            end
            if (seen < WORD_LEN_DEF) seen++;
            if (is_last) begin
                n_seqs++;
                while (held_bytes.size() > 0) release_oldest(held_bytes.size() == 1);
                restart();
            end
        endfunction

        function void check_byte(t_byte data, logic masked, logic is_last);
            t_out want;
            if (due_bytes.size() == 0) begin
                $error("output byte 0x%02h arrived with nothing expected", data);
                errors++;
                return;
            end
            want = due_bytes.pop_front();
            n_out++;
            if (want.masked) n_masked++;
            if (data !== want.data) begin
                $error("out_byte: expected 0x%02h, got 0x%02h", want.data, data);
                errors++;
            end
            if (masked !== want.masked) begin
                $error("was_masked: expected %0b, got %0b", want.masked, masked);
                errors++;
            end
            if (is_last !== want.last) begin
                $error("out_last: expected %0b, got %0b", want.last, is_last);
                errors++;
            end
        endfunction
    endclass
endpackage

module tb_kmer_repeat_masker;
    import kmr_pkg::*;
    import kmr_bench_pkg::*;

    // Let the whole pending buffer and the output queue drain twice over.
    localparam int SETTLE_CYCLES  = 2 * HOLD_DEPTH + 8;
    // Receiver hold-off: long enough for the buffer and queue to fill and block the input.
    localparam int HOLD_CYCLES    = 120;
    // Well over the quiet table clearing pass that follows reset.
    localparam int WATCHDOG_LIMIT = 300000;

    logic                   i_clk   = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic                   s_axis_tlast  = 1'b0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [BYTE_W-1:0]      m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   m_axis_tuser;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic                   i_cfg_index = 1'b0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    logic                   calm      = 1'b0;   // no idling on either side
    int                     hold_reqs = 0;      // bumped to ask for a receiver hold-off
    int                     holds_done = 0;
    int                     hold_left  = 0;
    int                     quiet      = 0;

    repeat_mask_scoreboard  sb;
    t_byte                  hot_word [WORD_LEN_DEF];
    t_tidx                  hot_idx;
    t_byte                  base_chars [4] = '{CHAR_A, CHAR_C, CHAR_G, CHAR_T};

    always #2 i_clk = ~i_clk;

    kmer_repeat_masker i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Check every result request against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_byte(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    // Receiver: random stalls, none while calm, and a counted hold-off on request.
    always @(posedge i_clk) begin
        if (holds_done != hold_reqs) begin
            holds_done = hold_reqs;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (calm) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= 31);
        end
    end

    // Watchdog: end the run if no request of any kind moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
                if (quiet >= WATCHDOG_LIMIT) begin
                    $display("no request moved for %0d cycles", quiet);
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    // Offer one input request, idling first at random unless calm; leave tvalid
    // high afterwards so back-to-back calm requests never drop it for a step.
    task automatic send_req(logic cmd, t_byte b, logic is_last, t_tidx idx, t_count cnt);
        if (!calm) begin
            while ($urandom_range(99) < 31) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tlast  <= is_last;
        s_axis_tdata  <= {cnt, idx, b};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(cmd, b, is_last, idx, cnt);
    endtask

    // Table load; the byte and last fields carry noise the block must ignore.
    task automatic load_count(t_tidx idx, t_count cnt);
        send_req(CMD_LOAD, t_byte'($urandom), 1'($urandom), idx, cnt);
    endtask

    // Send one whole sequence, tlast on its final byte; unused fields carry noise.
    task automatic send_bytes(t_byte seq[$]);
        foreach (seq[i])
            send_req(CMD_SEQ, seq[i], i == seq.size() - 1, t_tidx'($urandom), t_count'($urandom));
    endtask

    // Pick a fresh frequent word of random bases and work out its table index.
    task automatic make_hot();
        logic [1:0] code;
        for (int i = 0; i < WORD_LEN_DEF; i++) begin
            code        = 2'($urandom_range(3));
            hot_word[i] = base_chars[code];
            hot_idx     = {hot_idx[TABLE_AW-3:0], code};
        end
    endtask

    // Mostly bases with the frequent word dropped in; pads and arbitrary bytes as noise.
    task automatic random_sequence(int len);
        t_byte seq[$];
        int    pick;
        while (seq.size() < len) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                foreach (hot_word[k]) seq.push_back(hot_word[k]);
            end else if (pick < 20) begin
                seq.push_back(CHAR_PAD);
            end else if (pick < 30) begin
                seq.push_back(t_byte'($urandom));
            end else begin
                seq.push_back(base_chars[$urandom_range(3)]);
            end
        end
        send_bytes(seq);
    endtask

    // Hold the input until every predicted byte has come out, then let the block settle.
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        while (sb.due_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers back to back; valid stays high across the pair.
    task automatic set_config(t_count thr, t_byte mch);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_THRESHOLD;
        i_cfg_data  <= thr;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(CFG_THRESHOLD, thr);
        i_cfg_index <= CFG_MASK_CHAR;
        i_cfg_data  <= t_count'(mch);
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(CFG_MASK_CHAR, t_count'(mch));
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        t_byte  seq[$];
        t_count thr;
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: threshold met exactly, non-base k-mer, unloaded entry, pad at the start,
        // an input byte equal to the mask character, a gap cut short by the end.
        set_config(16'd5, MASK_CHAR_RST);
        make_hot();
        load_count(hot_idx, 16'd5);
        load_count('1, 16'hFFFF);
        load_count('0, 16'd0);
        seq.push_back(CHAR_PAD);
        foreach (hot_word[k]) seq.push_back(hot_word[k]);
        seq.push_back(CHAR_T);
        seq.push_back(CHAR_C);
        seq.push_back(MASK_CHAR_RST);
        seq.push_back(CHAR_G);
        seq.push_back(CHAR_T);
        send_bytes(seq);
        // Short sequence, never reaches a lookup: byte extremes and a lowercase base.
        seq = '{8'h00, CHAR_A, 8'hFF, 8'h67, CHAR_C};
        send_bytes(seq);
        quiesce();

        // Threshold zero: every lookup from the word length on hits and masks.
        set_config(16'd0, 8'hFF);
        random_sequence(12);
        quiesce();

        // Top threshold: only a full count masks.
        set_config(16'hFFFF, 8'h00);
        make_hot();
        load_count(hot_idx, 16'hFFFF);
        random_sequence(12);
        quiesce();

        // Random threshold, no idling on either side.
        thr = t_count'($urandom_range(1, 300));
        set_config(thr, t_byte'($urandom));
        make_hot();
        calm <= 1'b1;
        load_count(hot_idx, thr + t_count'($urandom_range(0, 3)));
        repeat (2) random_sequence($urandom_range(4, 10));
        calm <= 1'b0;
        quiesce();

        // Receiver holds off while a long sequence keeps coming: fill up and block.
        hold_reqs <= hold_reqs + 1;
        random_sequence(24);
        quiesce();

        // Mixed loads and sequences; the frequent word sits just below or at the threshold.
        repeat (3) begin
            if ($urandom_range(1)) load_count(t_tidx'($urandom), t_count'($urandom));
            load_count(hot_idx, $urandom_range(1) ? thr : thr - 16'd1);
            random_sequence($urandom_range(1, 8));
        end
        quiesce();

        $display("covered %0d sequences of %0d bytes and %0d table loads", sb.n_seqs,
                 sb.n_bytes, sb.n_loads);
        $display("checked %0d output bytes, %0d of them masked", sb.n_out, sb.n_masked);
        if (sb.errors == 0 && sb.due_bytes.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
